@@ src/i2cm_pkg.sv @@
// Shared types, constants and helpers for the I2C master bit sequencer.
package i2cm_pkg;

    localparam int unsigned MAX_BURST_I = 255;
    localparam logic [7:0]  MAX_BURST   = 8'(MAX_BURST_I);
    localparam logic [7:0]  READ_BIT    = 8'h01;
    localparam int unsigned Q_DEPTH     = 2;
    localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_BURST = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        BS_START,
        BS_DEV,
        BS_REG,
        BS_RESTART,
        BS_DEV_RD,
        BS_READ,
        BS_STOP
    } t_stage;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] count;
        logic       sda_in;
    } t_beat;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       ack_valid;
        logic       ack_bit;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_result;

    typedef struct packed {
        logic [2:0] q;
        logic [1:0] r;
    } t_div3;

    // Split a phase into bit slot and step within the slot: q = (p * 11) >> 5.
    function automatic t_div3 div3(input logic [4:0] p);
        logic [8:0] prod;
        logic [3:0] quo;
        logic [4:0] rem;
        t_div3      res;
        prod  = {4'd0, p} * 9'd11;
        quo   = prod[8:5];
        rem   = p - 5'({quo, 1'b0} + {1'b0, quo});
        res.q = quo[2:0];
        res.r = rem[1:0];
        return res;
    endfunction

endpackage

@@ src/i2cm_in_if.sv @@
// Input channel: one bus phase tick per beat.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic       sda_in;

    modport source (
        output valid, cmd, tx_byte, send_nack, dev_addr, reg_addr, count, sda_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, tx_byte, send_nack, dev_addr, reg_addr, count, sda_in,
        output ready
    );
endinterface

@@ src/i2cm_out_if.sv @@
// Output channel: line levels and flags for one tick per beat.
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       ack_valid;
    logic       ack_bit;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (
        output valid, scl_level, sda_level, busy_res, ack_valid, ack_bit,
               rx_valid, rx_byte, rx_last,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, ack_valid, ack_bit,
               rx_valid, rx_byte, rx_last,
        output ready
    );
endinterface

@@ src/i2cm_front.sv @@
// Front end: classify incoming tick beats and hold them in a short queue.
module i2cm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cm_in_if.sink           i_in,
    output logic              o_q_valid,
    output i2cm_pkg::t_beat   o_q_beat,
    input  logic              i_q_ready
);
    import i2cm_pkg::*;

    t_beat                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    t_beat                n_beat;
    logic                 push;
    logic                 pop;

    always_comb begin
        n_beat.cmd = CMD_NONE;
        if (i_in.cmd >= CMD_START && i_in.cmd <= CMD_BURST) begin
            n_beat.cmd = t_cmd'(i_in.cmd);
        end
        n_beat.tx_byte   = i_in.tx_byte;
        n_beat.send_nack = i_in.send_nack;
        n_beat.dev_addr  = i_in.dev_addr;
        n_beat.reg_addr  = i_in.reg_addr;
        n_beat.count     = (i_in.count > MAX_BURST) ? MAX_BURST : i_in.count;
        n_beat.sda_in    = i_in.sda_in;
    end

    assign i_in.ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_beat   = r_q[r_rd_ptr];
    assign push       = i_in.valid && i_in.ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/i2cm_seq.sv @@
// Back end: bus sequencer that performs one line operation per tick beat.
module i2cm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  i2cm_pkg::t_beat   i_q_beat,
    output logic              o_q_ready,
    i2cm_out_if.source        o_out
);
    import i2cm_pkg::*;

    t_cmd       r_active, n_active;
    t_stage     r_stage, n_stage;
    logic [4:0] r_phase, n_phase;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_left, n_left;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic       r_nack, n_nack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    t_cmd       kind;
    t_div3      wd;
    t_div3      rd;
    logic       done;
    logic       take;

    assign take      = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_q_ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_active = r_active;
        n_stage  = r_stage;
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_left   = r_left;
        n_dev    = r_dev;
        n_reg    = r_reg;
        n_nack   = r_nack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        res      = '0;
        kind     = CMD_NONE;
        done     = 1'b0;
        wd       = div3(r_phase);
        rd       = div3(r_phase - 5'd1);

        if (take) begin
            // load a new command only while idle
            if (r_active == CMD_NONE && i_q_beat.cmd != CMD_NONE) begin
                n_active = i_q_beat.cmd;
                n_phase  = '0;
                unique case (i_q_beat.cmd)
                    CMD_WRITE: n_shift = i_q_beat.tx_byte;
                    CMD_READ: begin
                        n_shift = '0;
                        n_nack  = i_q_beat.send_nack;
                    end
                    CMD_BURST: begin
                        n_dev   = i_q_beat.dev_addr;
                        n_reg   = i_q_beat.reg_addr;
                        n_left  = i_q_beat.count;
                        n_stage = BS_START;
                    end
                    default: ;
                endcase
            end

            wd = div3(n_phase);
            rd = div3(n_phase - 5'd1);

            if (n_active != CMD_NONE) begin
                res.busy_res = 1'b1;
                if (n_active == CMD_BURST) begin
                    unique case (n_stage)
                        BS_START, BS_RESTART:        kind = CMD_START;
                        BS_DEV, BS_REG, BS_DEV_RD:   kind = CMD_WRITE;
                        BS_READ:                     kind = CMD_READ;
                        default:                     kind = CMD_STOP;
                    endcase
                end else begin
                    kind = n_active;
                end

                unique case (kind)
                    CMD_START: begin
                        unique case (n_phase)
                            5'd0:    n_sda = 1'b1;
                            5'd1:    n_scl = 1'b1;
                            5'd2:    n_sda = 1'b0;
                            default: n_scl = 1'b0;
                        endcase
                        done = (n_phase >= 5'd3);
                    end
                    CMD_STOP: begin
                        unique case (n_phase)
                            5'd0:    n_sda = 1'b0;
                            5'd1:    n_scl = 1'b1;
                            default: n_sda = 1'b1;
                        endcase
                        done = (n_phase >= 5'd2);
                    end
                    CMD_WRITE: begin
                        if (n_phase < 5'd24) begin
                            unique case (wd.r)
                                2'd0:    n_sda = n_shift[3'd7 - wd.q];
                                2'd1:    n_scl = 1'b1;
                                default: n_scl = 1'b0;
                            endcase
                        end else begin
                            unique case (n_phase)
                                5'd24:   n_sda = 1'b1;
                                5'd25:   n_scl = 1'b1;
                                5'd26: begin
                                    res.ack_valid = 1'b1;
                                    res.ack_bit   = i_q_beat.sda_in;
                                end
                                default: n_scl = 1'b0;
                            endcase
                            done = (n_phase >= 5'd27);
                        end
                    end
                    default: begin
                        if (n_phase == 5'd0) begin
                            n_sda = 1'b1;
                        end else if (n_phase <= 5'd24) begin
                            unique case (rd.r)
                                2'd0:    n_scl = 1'b1;
                                2'd1: begin
                                    if (i_q_beat.sda_in) begin
                                        n_shift[3'd7 - rd.q] = 1'b1;
                                    end
                                    if (rd.q == 3'd7) begin
                                        res.rx_valid = 1'b1;
                                        res.rx_byte  = n_shift;
                                        res.rx_last  = (n_active == CMD_BURST) ?
                                                       (n_left == 8'd1) : 1'b1;
                                    end
                                end
                                default: n_scl = 1'b0;
                            endcase
                        end else begin
                            unique case (n_phase)
                                5'd25:   n_sda = n_nack;
                                5'd26:   n_scl = 1'b1;
                                default: n_scl = 1'b0;
                            endcase
                            done = (n_phase >= 5'd27);
                        end
                    end
                endcase

                if (!done) begin
                    n_phase = n_phase + 5'd1;
                end else begin
                    n_phase = '0;
                    if (n_active != CMD_BURST) begin
                        n_active = CMD_NONE;
                    end else begin
                        unique case (n_stage)
                            BS_START: begin
                                n_stage = BS_DEV;
                                n_shift = n_dev;
                            end
                            BS_DEV: begin
                                n_stage = BS_REG;
                                n_shift = n_reg;
                            end
                            BS_REG: n_stage = BS_RESTART;
                            BS_RESTART: begin
                                n_stage = BS_DEV_RD;
                                n_shift = n_dev | READ_BIT;
                            end
                            BS_DEV_RD: begin
                                if (n_left != '0) begin
                                    n_stage = BS_READ;
                                    n_shift = '0;
                                    n_nack  = (n_left == 8'd1);
                                end else begin
                                    n_stage = BS_STOP;
                                end
                            end
                            BS_READ: begin
                                if (n_left != '0) begin
                                    n_left = n_left - 8'd1;
                                end
                                if (n_left != '0) begin
                                    n_shift = '0;
                                    n_nack  = (n_left == 8'd1);
                                end else begin
                                    n_stage = BS_STOP;
                                end
                            end
                            default: begin
                                n_stage  = BS_START;
                                n_active = CMD_NONE;
                            end
                        endcase
                    end
                end
            end

            res.scl_level = n_scl;
            res.sda_level = n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CMD_NONE;
            r_stage     <= BS_START;
            r_phase     <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_dev       <= '0;
            r_reg       <= '0;
            r_nack      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_stage  <= n_stage;
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_left   <= n_left;
            r_dev    <= n_dev;
            r_reg    <= n_reg;
            r_nack   <= n_nack;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl_level = r_out.scl_level;
    assign o_out.sda_level = r_out.sda_level;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.ack_valid = r_out.ack_valid;
    assign o_out.ack_bit   = r_out.ack_bit;
    assign o_out.rx_valid  = r_out.rx_valid;
    assign o_out.rx_byte   = r_out.rx_byte;
    assign o_out.rx_last   = r_out.rx_last;

endmodule

@@ src/i2c_master_bit_sequencer_top.sv @@
// Top level of the I2C master bit sequencer: front queue, sequencer and checks.
// Each input beat is one bus phase tick and yields exactly one output beat
// with the SCL/SDA drive levels after that tick, busy, any sampled ack and any
// received byte. One beat is taken every clock while the output accepts;
// each result passes through the two-entry front queue and then the
// sequencer's output register, and the single-step sequencer update per
// tick sets that rate. Commands are obeyed only while no sequence is
// running; a burst read saturates its count at MAX_BURST.
module i2c_master_bit_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_out
);
    import i2cm_pkg::*;

    logic  q_valid;
    logic  q_ready;
    t_beat q_beat;

    i2cm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_beat  (q_beat),
        .i_q_ready (q_ready)
    );

    i2cm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_beat  (q_beat),
        .o_q_ready (q_ready),
        .o_out     (o_out)
    );

    a_ack_rx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.ack_valid && o_out.rx_valid))
        else $error("ack and received byte in one beat");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.busy_res) |-> (!o_out.ack_valid && !o_out.rx_valid))
        else $error("flag raised on idle tick");

    a_rx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.rx_valid) |-> (o_out.rx_byte == 8'd0 && !o_out.rx_last))
        else $error("received byte fields set without a byte");

    a_queue_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |=> o_out.valid)
        else $error("queued beat lost before output");

endmodule
